// ===== hw/rtl/dfe_pkg.sv =====
`timescale 1ns / 1ps

package dfe_pkg;

   localparam int unsigned STATE_W = 2;
   localparam int unsigned DUTY_W  = 7;
   localparam int unsigned TIME_W  = 10;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned SLICE_W = 6;

   localparam logic [TIME_W-1:0]  TIME_CAP      = 10'd630;
   localparam logic [TIME_W-1:0]  SLICE_ROUND   = 10'd9;
   // x / 10 == (x * 205) >> 11 for every x below 1029
   localparam logic [17:0]        RECIP_10      = 18'd205;
   localparam int unsigned        RECIP_SHIFT   = 11;
   localparam logic [COUNT_W-1:0] BUDGET_RESET  = 11'd1024;

   typedef struct packed {
      logic [STATE_W-1:0] frame_state;
      logic [DUTY_W-1:0]  frame_duty;
      logic [TIME_W-1:0]  frame_time;
      logic               frame_last;
   } req_item_type;

   typedef struct packed {
      logic [STATE_W-1:0] point_state;
      logic [DUTY_W-1:0]  point_duty;
      logic [INDEX_W-1:0] point_index;
      logic               run_last;
      logic               action_end;
   } rsp_item_type;

   // classified frame waiting for the back end
   typedef struct packed {
      logic [STATE_W-1:0] st;
      logic [DUTY_W-1:0]  du;
      logic [SLICE_W-1:0] cnt;
      logic               last;
      logic               append;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_port_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_APPEND
   } back_state_type;

endpackage

// ===== hw/rtl/dfe_front.sv =====
`timescale 1ns / 1ps

module dfe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  dfe_pkg::req_item_type req_item,
   output dfe_pkg::cmd_port_type cmd_out,
   input  logic                  cmd_take
);
   import dfe_pkg::*;

   localparam int unsigned DEPTH = 2;

   cmd_type           q_ff [DEPTH];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        fill_ff, fill_in;

   logic [TIME_W-1:0] tm_cap;
   logic [17:0]       prod;
   logic              keep;
   logic              push_q;
   logic              pop_q;
   cmd_type           cmd_new;

   always_comb begin
      tm_cap = (req_item.frame_time > TIME_CAP) ? TIME_CAP : req_item.frame_time;
      prod   = (18'(tm_cap) + 18'(SLICE_ROUND)) * RECIP_10;
      cmd_new.st   = req_item.frame_state;
      cmd_new.du   = req_item.frame_duty;
      cmd_new.last = req_item.frame_last;
      if (tm_cap == '0) begin
         // a hold frame that is not the last is dropped; a last one gives one point and never an idle tail
         cmd_new.cnt    = SLICE_W'(1);
         cmd_new.append = 1'b0;
         keep           = req_item.frame_last;
      end else begin
         cmd_new.cnt    = prod[RECIP_SHIFT +: SLICE_W];
         cmd_new.append = req_item.frame_last;
         keep           = 1'b1;
      end
   end

   assign req_full      = (fill_ff == 2'(DEPTH));
   assign push_q        = req_push && !req_full && keep;
   assign cmd_out.valid = (fill_ff != 2'd0);
   assign cmd_out.cmd   = q_ff[rd_ff];
   assign pop_q         = cmd_take && cmd_out.valid;

   always_comb begin
      wr_in   = push_q ? ~wr_ff : wr_ff;
      rd_in   = pop_q ? ~rd_ff : rd_ff;
      fill_in = fill_ff + 2'(push_q) - 2'(pop_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         q_ff[wr_ff] <= cmd_new;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(DEPTH))
      else $error("command queue over-filled");

endmodule

// ===== hw/rtl/dfe_back.sv =====
`timescale 1ns / 1ps

module dfe_back #(
   parameter int unsigned MAX_POINTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dfe_pkg::cmd_port_type         cmd_in,
   output logic                          cmd_take,
   input  logic                          csr_we,
   input  logic [dfe_pkg::COUNT_W-1:0]   csr_wdata,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output dfe_pkg::rsp_item_type         rsp_item
);
   import dfe_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_CAP =
      (MAX_POINTS > 2047) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_POINTS);

   back_state_type     state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [SLICE_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0] done_ff, done_in;
   logic [COUNT_W-1:0] budget_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff, out_item_in;

   logic [COUNT_W-1:0] budget_eff;
   logic               exhaust_now;
   logic               exhaust_after;
   logic               can_emit;
   logic               emit;
   logic               frame_end;
   logic               will_append;
   rsp_item_type       point;

   always_comb begin
      budget_eff    = (budget_ff > MAX_CAP) ? MAX_CAP : budget_ff;
      exhaust_now   = (done_ff >= budget_eff);
      exhaust_after = ((12'(done_ff) + 12'd1) >= 12'(budget_eff));
      can_emit      = !out_valid_ff || rsp_pop;
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      done_in     = done_ff;
      cmd_take    = 1'b0;
      emit        = 1'b0;
      frame_end   = 1'b0;
      will_append = 1'b0;
      point.point_state = cur_ff.st;
      point.point_duty  = cur_ff.du;
      point.point_index = done_ff[INDEX_W-1:0];
      point.run_last    = 1'b0;
      point.action_end  = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_in.valid) begin
               cmd_take = 1'b1;
               cur_in   = cmd_in.cmd;
               cnt_in   = cmd_in.cmd.cnt;
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (exhaust_now) begin
               state_in = BK_IDLE;
               if (cur_ff.last) done_in = '0;
            end else if (can_emit) begin
               emit        = 1'b1;
               frame_end   = exhaust_after || (cnt_ff == SLICE_W'(1));
               will_append = cur_ff.append && !exhaust_after &&
                             ((cur_ff.st != '0) || (cur_ff.du != '0));
               point.run_last   = frame_end && !will_append;
               point.action_end = frame_end && !will_append && cur_ff.last;
               done_in = done_ff + COUNT_W'(1);
               cnt_in  = cnt_ff - SLICE_W'(1);
               if (frame_end) begin
                  if (will_append) begin
                     state_in = BK_APPEND;
                  end else begin
                     state_in = BK_IDLE;
                     if (cur_ff.last) done_in = '0;
                  end
               end
            end
         end
         BK_APPEND: begin
            if (can_emit) begin
               // idle tail at zero duty closes the action
               emit              = 1'b1;
               point.point_state = '0;
               point.point_duty  = '0;
               point.run_last    = 1'b1;
               point.action_end  = cur_ff.last;
               state_in          = BK_IDLE;
               done_in           = '0;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_item_in  = point;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         done_ff      <= '0;
         budget_ff    <= BUDGET_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) budget_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      out_item_ff <= out_item_in;
   end

   a_append_only_if_allowed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_APPEND) |-> cur_ff.append)
      else $error("idle tail without a closing frame");

   a_run_has_points: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_RUN) |-> (cnt_ff != '0))
      else $error("sequencer running with no points left");

   a_end_marks_run: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.action_end) |-> out_item_ff.run_last)
      else $error("action end on a point that does not close its frame");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_item_ff)))
      else $error("waiting point overwritten");

endmodule

// ===== hw/rtl/drive_frame_expander_top.sv =====
`timescale 1ns / 1ps

// channel | ports                              | direction
// --------+------------------------------------+-----------
// request | req_push, req_full, req_item       | in
// result  | rsp_empty, rsp_pop, rsp_item       | out
// csr     | csr_we, csr_wdata (point budget)   | in
//
// the back sequencer takes a frame's command, emits its points and, when one is appended, an idle
// tail; it emits one point per cycle within a frame while its result is not stalled
// a two-entry command queue lets the front take frames while the back works
// reset is synchronous and clears queue, point counter and budget (to 1024)
// a stalled result holds the sequencer; the front stalls only when its queue is full

module drive_frame_expander_top #(
   parameter int unsigned MAX_POINTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  dfe_pkg::req_item_type         req_item,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output dfe_pkg::rsp_item_type         rsp_item,
   input  logic                          csr_we,
   input  logic [dfe_pkg::COUNT_W-1:0]   csr_wdata
);
   import dfe_pkg::*;

   cmd_port_type cmd;
   logic         cmd_take;

   dfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cmd_out  (cmd),
      .cmd_take (cmd_take)
   );

   dfe_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (cmd),
      .cmd_take  (cmd_take),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
